// ----- hw/rtl/union_find_component_counter_macros.svh -----
// Assertion helpers for the component counter; the clock and reset names are fixed.
`ifndef UNION_FIND_COMPONENT_COUNTER_MACROS_SVH
`define UNION_FIND_COMPONENT_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
`define UFCC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ufcc assertion failed");
`define UFCC_ASSERT_NEVER(label, cond) `UFCC_ASSERT(label, !(cond))
`else
`define UFCC_ASSERT(label, prop)
`define UFCC_ASSERT_NEVER(label, cond)
`endif

`endif

// ----- hw/rtl/ufcc_pkg.sv -----
package ufcc_pkg;

  localparam int unsigned NodeW = 14;

  typedef struct packed {
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] component_total;
    logic             joined;
    logic             bad_node;
  } out_item_t;

  // finished edge, handed from the walker to the count and output logic
  typedef struct packed {
    logic valid;
    logic joined;
    logic bad;
  } walk_evt_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_EMIT
  } walk_state_e;

endpackage

// ----- hw/rtl/ufcc_parent_mem.sv -----
module ufcc_parent_mem #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned AddrW = 14
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [AddrW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [AddrW-1:0] rdata_o
);

  logic [AddrW-1:0] mem_q [Depth];
  logic [AddrW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ufcc_walk_ctrl.sv -----
module ufcc_walk_ctrl #(
  parameter int unsigned AddrW = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ufcc_pkg::NodeW-1:0] node_count_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ufcc_pkg::in_item_t         in_data_i,
  input  logic                       out_free_i,
  output ufcc_pkg::walk_evt_t        evt_o,
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_waddr_o,
  output logic [AddrW-1:0]           mem_wdata_o,
  output logic [AddrW-1:0]           mem_raddr_o,
  input  logic [AddrW-1:0]           mem_rdata_i
);

  ufcc_pkg::walk_state_e state_q, state_d;

  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] cur_q, cur_d;
  logic [AddrW-1:0] root_a_q, root_a_d;
  logic [AddrW-1:0] b_q, b_d;
  logic             joined_q, joined_d;
  logic             bad_q, bad_d;

  logic in_bad;
  logic at_root;
  logic clr_last;

  assign in_bad = (in_data_i.node_a == '0) || (in_data_i.node_b == '0) ||
                  (in_data_i.node_a > node_count_i) || (in_data_i.node_b > node_count_i);
  assign at_root  = (mem_rdata_i == cur_q);
  assign clr_last = (clr_q == AddrW'(node_count_i));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ufcc_pkg::ST_CLEAR: begin
        if (clr_last) state_d = ufcc_pkg::ST_IDLE;
      end
      ufcc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = in_bad ? ufcc_pkg::ST_EMIT : ufcc_pkg::ST_WALK_A;
      end
      ufcc_pkg::ST_WALK_A: begin
        if (at_root) state_d = ufcc_pkg::ST_WALK_B;
      end
      ufcc_pkg::ST_WALK_B: begin
        if (at_root) state_d = ufcc_pkg::ST_EMIT;
      end
      ufcc_pkg::ST_EMIT: begin
        if (out_free_i) state_d = ufcc_pkg::ST_IDLE;
      end
      default: state_d = ufcc_pkg::ST_CLEAR;
    endcase
    // a new node count restarts the table sweep
    if (cfg_we_i) state_d = ufcc_pkg::ST_CLEAR;
  end

  // outputs and datapath next values
  always_comb begin
    in_ready_o   = 1'b0;
    evt_o        = '0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = clr_q;
    mem_wdata_o  = clr_q;
    mem_raddr_o  = cur_q;
    clr_d        = clr_q;
    cur_d        = cur_q;
    root_a_d     = root_a_q;
    b_d          = b_q;
    joined_d     = joined_q;
    bad_d        = bad_q;
    unique case (state_q)
      ufcc_pkg::ST_CLEAR: begin
        mem_we_o = 1'b1;
        clr_d    = clr_q + 1'b1;
      end
      ufcc_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        mem_raddr_o = AddrW'(in_data_i.node_a);
        if (in_valid_i) begin
          cur_d    = AddrW'(in_data_i.node_a);
          b_d      = AddrW'(in_data_i.node_b);
          bad_d    = in_bad;
          joined_d = 1'b0;
        end
      end
      ufcc_pkg::ST_WALK_A: begin
        if (at_root) begin
          mem_raddr_o = b_q;
          root_a_d    = cur_q;
          cur_d       = b_q;
        end else begin
          mem_raddr_o = mem_rdata_i;
          cur_d       = mem_rdata_i;
        end
      end
      ufcc_pkg::ST_WALK_B: begin
        mem_raddr_o = mem_rdata_i;
        if (at_root) begin
          // link the first root under the second
          joined_d    = (cur_q != root_a_q);
          mem_we_o    = (cur_q != root_a_q);
          mem_waddr_o = root_a_q;
          mem_wdata_o = cur_q;
        end else begin
          cur_d = mem_rdata_i;
        end
      end
      ufcc_pkg::ST_EMIT: begin
        evt_o.valid  = out_free_i;
        evt_o.joined = joined_q;
        evt_o.bad    = bad_q;
      end
      default: begin
      end
    endcase
    if (cfg_we_i) clr_d = AddrW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ufcc_pkg::ST_CLEAR;
      clr_q    <= AddrW'(1);
      joined_q <= 1'b0;
      bad_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      joined_q <= joined_d;
      bad_q    <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    root_a_q <= root_a_d;
    b_q      <= b_d;
  end

endmodule

// ----- hw/rtl/union_find_component_counter.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+--------------------------------------------
// in       | in_valid_i / in_ready_o | in_data_i   (node_a, node_b)
// out      | out_valid_o/ out_ready_i| out_data_o  (component_total, joined, bad_node)
// cfg      | cfg_we_i                | cfg_wdata_i (node_count)
//
// An edge walks from each of its two nodes up to that node's root; each walk
// step is one read of the parent memory.
// An edge with an out-of-range endpoint skips both walks and goes straight to its result.
// After reset and after each node_count write, a sweep of the parent memory
// rewrites the entries 1..node_count; no item is taken meanwhile.
// A finished result waits in the output register; the next item is taken
// only once that register has room for the result before it.
`include "union_find_component_counter_macros.svh"

module union_find_component_counter #(
  parameter int unsigned MAX_NODES = 16384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ufcc_pkg::NodeW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ufcc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ufcc_pkg::out_item_t           out_data_o
);

  localparam int unsigned AddrW   = $clog2(MAX_NODES);
  localparam int unsigned NodeMax = MAX_NODES - 1;

  logic [ufcc_pkg::NodeW-1:0] node_count_q, node_count_d;
  logic [ufcc_pkg::NodeW-1:0] rem_q, rem_d;
  logic [ufcc_pkg::NodeW-1:0] cfg_clamped;
  logic                       out_valid_q, out_valid_d;
  ufcc_pkg::out_item_t        out_data_q;
  logic                       out_free;
  ufcc_pkg::walk_evt_t        evt;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [AddrW-1:0] mem_rdata;

  ufcc_walk_ctrl #(
    .AddrW (AddrW)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .node_count_i (node_count_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_free_i   (out_free),
    .evt_o        (evt),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  ufcc_parent_mem #(
    .Depth (MAX_NODES),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // hold the node count inside 1..MAX_NODES-1
  always_comb begin
    cfg_clamped = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      cfg_clamped = ufcc_pkg::NodeW'(1);
    end else if (32'(cfg_wdata_i) > NodeMax) begin
      cfg_clamped = ufcc_pkg::NodeW'(NodeMax);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    node_count_d = node_count_q;
    rem_d        = rem_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (evt.valid) begin
      out_valid_d = 1'b1;
      if (evt.joined && (rem_q > ufcc_pkg::NodeW'(1))) rem_d = rem_q - 1'b1;
    end
    if (cfg_we_i) begin
      node_count_d = cfg_clamped;
      rem_d        = cfg_clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= ufcc_pkg::NodeW'(1);
      rem_q        <= ufcc_pkg::NodeW'(1);
      out_valid_q  <= 1'b0;
    end else begin
      node_count_q <= node_count_d;
      rem_q        <= rem_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt.valid) begin
      out_data_q.component_total <= rem_d;
      out_data_q.joined          <= evt.joined;
      out_data_q.bad_node        <= evt.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `UFCC_ASSERT(a_join_drops_count,
      (evt.valid && evt.joined && !cfg_we_i && (rem_q > ufcc_pkg::NodeW'(1)))
      |=> (rem_q == $past(rem_q) - 1'b1))
  `UFCC_ASSERT_NEVER(a_count_in_range, (rem_q == '0) || (rem_q > node_count_q))
  `UFCC_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o && !cfg_we_i) |=> !in_ready_o)
  `UFCC_ASSERT_NEVER(a_bad_never_joins, evt.valid && evt.joined && evt.bad)

endmodule

// ----- tb/sv/component_count_checker.sv -----
`timescale 1ns / 100ps

module component_count_checker #(
  parameter int unsigned MaxNodes = 16384
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ufcc_pkg::NodeW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  ufcc_pkg::in_item_t          in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  ufcc_pkg::out_item_t         out_data_i,
  output int                          fail_count_o,
  output int                          outstanding_o,
  output int                          merges_o,
  output int                          bad_edges_o
);

  localparam int unsigned IdW = ufcc_pkg::NodeW;

  logic [IdW-1:0]      parent_of [MaxNodes];
  logic [IdW-1:0]      node_limit;
  logic [IdW-1:0]      components_left;
  ufcc_pkg::out_item_t predicted_tallies [$];

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
    merges_o      = 0;
    bad_edges_o   = 0;
  end

  function automatic void rebuild_forest(input logic [IdW-1:0] count);
    node_limit = (count == '0) ? IdW'(1) : count;
    if (node_limit > IdW'(MaxNodes - 1)) begin
      node_limit = IdW'(MaxNodes - 1);
    end
    for (int i = 0; i < MaxNodes; i++) begin
      parent_of[i] = IdW'(i);
    end
    components_left = node_limit;
  endfunction

  function automatic logic [IdW-1:0] root_of(input logic [IdW-1:0] n);
    logic [IdW-1:0] cur;
    int             steps;
    cur   = n;
    steps = 0;
    while (steps < MaxNodes && parent_of[cur] != cur) begin
      cur = parent_of[cur];
      steps++;
    end
    return cur;
  endfunction

  function automatic ufcc_pkg::out_item_t predict_edge(input ufcc_pkg::in_item_t e);
    ufcc_pkg::out_item_t r;
    logic [IdW-1:0]      ra;
    logic [IdW-1:0]      rb;
    r.joined   = 1'b0;
    r.bad_node = 1'b0;
    if (e.node_a == '0 || e.node_b == '0 || e.node_a > node_limit ||
        e.node_b > node_limit) begin
      r.bad_node = 1'b1;
    end else begin
      ra = root_of(e.node_a);
      rb = root_of(e.node_b);
      if (ra != rb) begin
        // link the first root under the second
        parent_of[ra] = rb;
        if (components_left > IdW'(1)) begin
          components_left = components_left - 1'b1;
        end
        r.joined = 1'b1;
      end
    end
    r.component_total = components_left;
    return r;
  endfunction

  function automatic void compare_tally(input ufcc_pkg::out_item_t got);
    ufcc_pkg::out_item_t want;
    if (predicted_tallies.size() == 0) begin
      $error("unexpected result item: component_total=%0d joined=%0b bad_node=%0b",
             got.component_total, got.joined, got.bad_node);
      fail_count_o++;
      return;
    end
    want = predicted_tallies.pop_front();
    if (got.component_total !== want.component_total) begin
      $error("component_total: expected %0d, got %0d", want.component_total,
             got.component_total);
      fail_count_o++;
    end
    if (got.joined !== want.joined) begin
      $error("joined: expected %0b, got %0b", want.joined, got.joined);
      fail_count_o++;
    end
    if (got.bad_node !== want.bad_node) begin
      $error("bad_node: expected %0b, got %0b", want.bad_node, got.bad_node);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ufcc_pkg::out_item_t p;
    if (!rst_ni) begin
      rebuild_forest(IdW'(1));
      predicted_tallies.delete();
    end else begin
      // results first: a result can never belong to an edge taken at the same edge
      if (out_valid_i && out_ready_i) begin
        compare_tally(out_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        p = predict_edge(in_data_i);
        if (p.joined) merges_o++;
        if (p.bad_node) bad_edges_o++;
        predicted_tallies.insert(predicted_tallies.size(), p);
      end
      if (cfg_we_i) begin
        rebuild_forest(cfg_wdata_i);
      end
    end
    outstanding_o = predicted_tallies.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned    IdW           = ufcc_pkg::NodeW;
  localparam int unsigned    MaxNodes      = 16384;
  localparam logic [IdW-1:0] TopId         = IdW'(MaxNodes - 1);
  localparam int             ItemsTarget   = 1720;
  // worst stretch without a handshake: full sweep plus two full walks plus stalls
  localparam int             WatchdogLimit = 200000;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [IdW-1:0]      cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ufcc_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ufcc_pkg::out_item_t out_data;

  int fail_count;
  int outstanding;
  int merges;
  int bad_edges;
  int edges_sent      = 0;
  int settings_loaded = 0;
  int idle_cycles     = 0;
  bit steady          = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  union_find_component_counter #(
    .MAX_NODES(MaxNodes)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  component_count_checker #(
    .MaxNodes(MaxNodes)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding),
    .merges_o     (merges),
    .bad_edges_o  (bad_edges)
  );

  function automatic int pause_len();
    return steady ? 0 : int'($urandom_range(0, 11));
  endfunction

  task automatic send_edge(input logic [IdW-1:0] a, input logic [IdW-1:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) steady = !steady;
    gap = pause_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{node_a: a, node_b: b};
    do @(posedge clk_i); while (!in_ready);
    edges_sent++;
  endtask

  // drop valid and wait until every edge has reported back
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic load_node_count(input logic [IdW-1:0] v);
    drain();
    repeat (4) @(negedge clk_i);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // result side: random stall per item, then hold ready until one is taken
  initial begin
    int stall;
    forever begin
      stall = pause_len();
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [IdW-1:0] n;
    logic [IdW-1:0] span;
    logic [IdW-1:0] a;
    logic [IdW-1:0] b;
    logic [IdW-1:0] wild;
    int             pick;
    int             roll;
    int             phase_len;
    bit             chain;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (8) @(negedge clk_i);

    // reset setting: a single node
    send_edge(IdW'(1), IdW'(1));
    send_edge(IdW'(0), IdW'(0));
    send_edge(IdW'(1), IdW'(2));
    send_edge(TopId, TopId);

    // zero is stored as one
    load_node_count('0);
    send_edge(IdW'(1), IdW'(1));
    send_edge(IdW'(0), IdW'(1));

    load_node_count(TopId);
    send_edge(IdW'(1), TopId);
    send_edge(TopId, IdW'(2));
    send_edge(IdW'(2), IdW'(1));
    send_edge(IdW'(0), IdW'(5));
    send_edge(IdW'(5), IdW'(0));
    send_edge(TopId, TopId);

    // merge everything, then the count holds at one
    load_node_count(IdW'(5));
    send_edge(IdW'(1), IdW'(2));
    send_edge(IdW'(2), IdW'(3));
    send_edge(IdW'(3), IdW'(4));
    send_edge(IdW'(4), IdW'(5));
    send_edge(IdW'(1), IdW'(5));
    send_edge(IdW'(6), IdW'(1));
    send_edge(IdW'(5), IdW'(1));

    while (edges_sent < ItemsTarget) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        n = TopId;
      end else if (pick == 1) begin
        n = IdW'($urandom_range(0, 3));
      end else if (pick == 2) begin
        n = IdW'($urandom_range(100, 2000));
      end else begin
        n = IdW'($urandom_range(4, 48));
      end
      load_node_count(n);
      span      = (n == '0) ? IdW'(1) : n;
      phase_len = (span > 200) ? 40 : int'($urandom_range(span, 3 * span + 4));
      chain     = ($urandom_range(0, 2) == 0);

      for (int k = 0; k < phase_len && edges_sent < ItemsTarget; k++) begin
        roll = $urandom_range(0, 99);
        a    = IdW'($urandom_range(1, span));
        b    = IdW'($urandom_range(1, span));
        if (roll < 8) begin
          a = IdW'($urandom_range(0, TopId));
          b = IdW'($urandom_range(0, TopId));
        end else if (roll < 15) begin
          // out-of-range id on one end
          wild = (span == TopId || $urandom_range(0, 2) == 0) ? IdW'(0)
                 : IdW'($urandom_range(span + 1, TopId));
          if ($urandom_range(0, 1) == 0) a = wild;
          else b = wild;
        end else if (chain && k < span - 1 && k < 40) begin
          // grow one long chain so later walks go deep
          a = IdW'(k + 1);
          b = IdW'(k + 2);
        end else if (chain && $urandom_range(0, 3) == 0) begin
          a = IdW'(1);
        end
        send_edge(a, b);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d edges over %0d node-count settings: %0d merges, %0d out-of-range",
             edges_sent, settings_loaded, merges, bad_edges);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- union_find_component_counter.f -----
+incdir+hw/rtl
hw/rtl/ufcc_pkg.sv
hw/rtl/ufcc_parent_mem.sv
hw/rtl/ufcc_walk_ctrl.sv
hw/rtl/union_find_component_counter.sv
tb/sv/component_count_checker.sv
tb/sv/tb_top.sv
